// File: hw/rtl/sotv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sotv_pkg
// Types, codes and helper functions shared by the script opcode stream
// validator modules.
// ----------------------------------------------------------------------------
package sotv_pkg;

   // Default sizes handed to the top level parameters.
   localparam int COND_DEPTH_DEFAULT  = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Configuration port.
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_MINIMAL_PUSH_CHECK     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNDEFINED_OPCODE = 8'd1;
   localparam logic [7:0]             FIRST_UNDEFINED_RESET      = 8'd186;

   // Byte roles.
   localparam logic [1:0] ROLE_OPCODE = 2'd0;
   localparam logic [1:0] ROLE_LENGTH = 2'd1;
   localparam logic [1:0] ROLE_DATA   = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_OPCODE = 3'd1;
   localparam logic [2:0] ERR_PUSH_SIZE  = 3'd2;
   localparam logic [2:0] ERR_MINIMAL    = 3'd3;
   localparam logic [2:0] ERR_UNBALANCED = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW   = 3'd5;

   // Opcodes of interest.
   localparam logic [7:0] OPC_PUSH_MAX  = 8'd75;
   localparam logic [7:0] OPC_PUSHDATA1 = 8'd76;
   localparam logic [7:0] OPC_PUSHDATA2 = 8'd77;
   localparam logic [7:0] OPC_PUSHDATA4 = 8'd78;
   localparam logic [7:0] OPC_RESERVED  = 8'h50;
   localparam logic [7:0] OPC_IF        = 8'h63;
   localparam logic [7:0] OPC_NOTIF     = 8'h64;
   localparam logic [7:0] OPC_ELSE      = 8'h67;
   localparam logic [7:0] OPC_ENDIF     = 8'h68;
   localparam logic [7:0] OPC_RESERVED1 = 8'h89;
   localparam logic [7:0] OPC_RESERVED2 = 8'h8a;
   localparam logic [7:0] OPC_INVALID   = 8'hff;
   localparam logic [7:0] OPC_1NEGATE   = 8'h81;

   // Minimal push limits.
   localparam logic [31:0] MIN_PUSHDATA1 = 32'd76;
   localparam logic [31:0] MIN_PUSHDATA2 = 32'd256;
   localparam logic [31:0] MIN_PUSHDATA4 = 32'd65536;

   // Conditional stack marks.
   localparam logic [1:0] MARK_IF    = 2'd0;
   localparam logic [1:0] MARK_NOTIF = 2'd1;
   localparam logic [1:0] MARK_ELSE  = 2'd2;

   // Conditional operation carried from front to back.
   localparam logic [2:0] COND_NONE  = 3'd0;
   localparam logic [2:0] COND_IF    = 3'd1;
   localparam logic [2:0] COND_NOTIF = 3'd2;
   localparam logic [2:0] COND_ELSE  = 3'd3;
   localparam logic [2:0] COND_ENDIF = 3'd4;

   typedef struct packed {
      logic [7:0] script_byte;
      logic       end_of_script;
   } sotv_req_type;

   typedef struct packed {
      logic [7:0]  byte_echo;
      logic [1:0]  byte_role;
      logic [7:0]  current_opcode;
      logic        instruction_done;
      logic [31:0] push_size;
      logic [2:0]  error_code;
      logic        script_done;
   } sotv_rsp_type;

   typedef struct packed {
      logic       minimal_push_check;
      logic [7:0] first_undefined_opcode;
   } sotv_cfg_type;

   // Classified byte passed from the front to the back through the queue.
   typedef struct packed {
      logic [7:0]  byte_echo;
      logic [1:0]  byte_role;
      logic [7:0]  current_opcode;
      logic        instruction_done;
      logic [31:0] push_size;
      logic        script_done;
      logic [2:0]  pre_error;
      logic [2:0]  cond_op;
      logic        truncated;
   } sotv_item_type;

   function automatic logic is_bad_opcode(input logic [7:0] op,
                                          input logic [7:0] first_undef);
      return (op == OPC_INVALID) || (op == OPC_RESERVED) ||
             (op == OPC_RESERVED1) || (op == OPC_RESERVED2) ||
             (op >= first_undef);
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sotv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sotv_front
// Parses the byte stream into opcodes, push lengths and push data, and
// checks completed pushes and plain opcodes against the configuration.
// ----------------------------------------------------------------------------
module sotv_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  sotv_pkg::sotv_req_type req_item,
   input  sotv_pkg::sotv_cfg_type cfg,
   output sotv_pkg::sotv_item_type item
);
   import sotv_pkg::*;

   localparam logic [1:0] PH_OPCODE = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  len_left_ff, len_left_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] data_left_ff, data_left_in;
   logic [7:0]  fdv_ff, fdv_in;

   logic [7:0]  b;
   logic [2:0]  total;
   logic [1:0]  shift_idx;
   logic [31:0] accum_or;
   logic [31:0] data_dec;
   logic        finish_push;
   logic        finish_plain;
   logic        minimal;
   logic [2:0]  push_err;

   assign b = req_item.script_byte;

   always_comb begin
      phase_in      = phase_ff;
      len_left_in   = len_left_ff;
      opcode_in     = opcode_ff;
      accum_in      = accum_ff;
      data_left_in  = data_left_ff;
      fdv_in        = fdv_ff;
      item.byte_role        = ROLE_OPCODE;
      item.instruction_done = 1'b0;
      item.push_size        = '0;
      finish_push   = 1'b0;
      finish_plain  = 1'b0;
      total     = (opcode_ff == OPC_PUSHDATA1) ? 3'd1 :
                  (opcode_ff == OPC_PUSHDATA2) ? 3'd2 : 3'd4;
      shift_idx = 2'(total - len_left_ff);
      accum_or  = accum_ff | ({24'd0, b} << {shift_idx, 3'b000});
      data_dec  = data_left_ff - 32'd1;
      unique case (phase_ff)
         PH_LENGTH: begin
            item.byte_role = ROLE_LENGTH;
            accum_in       = accum_or;
            len_left_in    = len_left_ff - 3'd1;
            item.push_size = accum_or;
            if (len_left_ff == 3'd1) begin
               if (accum_or == 32'd0) begin
                  item.instruction_done = 1'b1;
                  phase_in    = PH_OPCODE;
                  finish_push = 1'b1;
               end else begin
                  data_left_in = accum_or;
                  phase_in     = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            item.byte_role = ROLE_DATA;
            item.push_size = accum_ff;
            if (data_left_ff == accum_ff) begin
               fdv_in = b;
            end
            data_left_in = data_dec;
            if (data_dec == 32'd0) begin
               item.instruction_done = 1'b1;
               phase_in    = PH_OPCODE;
               finish_push = 1'b1;
            end
         end
         default: begin
            opcode_in = b;
            fdv_in    = 8'd0;
            if (b <= OPC_PUSH_MAX) begin
               accum_in       = {24'd0, b};
               item.push_size = {24'd0, b};
               if (b == 8'd0) begin
                  item.instruction_done = 1'b1;
                  finish_push = 1'b1;
               end else begin
                  data_left_in = {24'd0, b};
                  phase_in     = PH_DATA;
               end
            end else if (b <= OPC_PUSHDATA4) begin
               accum_in    = '0;
               len_left_in = (b == OPC_PUSHDATA1) ? 3'd1 :
                             (b == OPC_PUSHDATA2) ? 3'd2 : 3'd4;
               phase_in    = PH_LENGTH;
            end else begin
               accum_in = '0;
               item.instruction_done = 1'b1;
               finish_plain = 1'b1;
            end
         end
      endcase

      // Minimal push rules on the completed push.
      minimal = 1'b1;
      if ((accum_in == 32'd1) &&
          ((fdv_in == OPC_1NEGATE) || ((fdv_in >= 8'd1) && (fdv_in <= 8'd16)))) begin
         minimal = 1'b0;
      end
      if ((opcode_in == OPC_PUSHDATA1) && (accum_in < MIN_PUSHDATA1)) minimal = 1'b0;
      if ((opcode_in == OPC_PUSHDATA2) && (accum_in < MIN_PUSHDATA2)) minimal = 1'b0;
      if ((opcode_in == OPC_PUSHDATA4) && (accum_in < MIN_PUSHDATA4)) minimal = 1'b0;

      if (is_bad_opcode(opcode_in, cfg.first_undefined_opcode)) begin
         push_err = ERR_BAD_OPCODE;
      end else if (cfg.minimal_push_check && !minimal) begin
         push_err = ERR_MINIMAL;
      end else begin
         push_err = ERR_NONE;
      end

      item.pre_error = ERR_NONE;
      item.cond_op   = COND_NONE;
      if (finish_push) begin
         item.pre_error = push_err;
      end else if (finish_plain) begin
         if (is_bad_opcode(b, cfg.first_undefined_opcode)) begin
            item.pre_error = ERR_BAD_OPCODE;
         end
         unique case (b)
            OPC_IF:    item.cond_op = COND_IF;
            OPC_NOTIF: item.cond_op = COND_NOTIF;
            OPC_ELSE:  item.cond_op = COND_ELSE;
            OPC_ENDIF: item.cond_op = COND_ENDIF;
            default:   item.cond_op = COND_NONE;
         endcase
      end

      item.byte_echo      = b;
      item.current_opcode = opcode_in;
      item.script_done    = req_item.end_of_script;
      item.truncated      = req_item.end_of_script && (phase_in != PH_OPCODE);

      if (req_item.end_of_script) begin
         phase_in     = PH_OPCODE;
         len_left_in  = '0;
         opcode_in    = '0;
         accum_in     = '0;
         data_left_in = '0;
         fdv_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         len_left_ff  <= '0;
         opcode_ff    <= '0;
         accum_ff     <= '0;
         data_left_ff <= '0;
         fdv_ff       <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         len_left_ff  <= len_left_in;
         opcode_ff    <= opcode_in;
         accum_ff     <= accum_in;
         data_left_ff <= data_left_in;
         fdv_ff       <= fdv_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/sotv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sotv_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module sotv_queue #(
   parameter int DEPTH = sotv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     wr_valid,
   input  sotv_pkg::sotv_item_type wr_item,
   output logic                    full,
   input  wire                     rd_pop,
   output logic                    rd_valid,
   output sotv_pkg::sotv_item_type rd_item
);
   import sotv_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   sotv_item_type  mem [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]  count_ff;
   logic           do_wr, do_rd;

   assign full     = (count_ff == CW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_valid && !full;
   assign do_rd    = rd_pop && rd_valid;
   assign rd_item  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/sotv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sotv_back
// Tracks conditional nesting, latches the first error of a script and
// holds the result register towards the response channel.
// ----------------------------------------------------------------------------
module sotv_back #(
   parameter int COND_DEPTH = sotv_pkg::COND_DEPTH_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     q_valid,
   input  sotv_pkg::sotv_item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output sotv_pkg::sotv_rsp_type  rsp_data
);
   import sotv_pkg::*;

   localparam int AW = (COND_DEPTH > 1) ? $clog2(COND_DEPTH) : 1;
   localparam int DW = $clog2(COND_DEPTH + 1);
   localparam logic [DW-1:0] FULL_DEPTH = DW'(COND_DEPTH);

   // The two top entries live in registers; the rest is read from memory.
   logic [1:0]    stack_mem [COND_DEPTH];
   logic [1:0]    top_ff, second_ff;
   logic [DW-1:0] depth_ff, depth_in;
   logic [2:0]    err_ff, err_in;

   logic          valid_ff;
   sotv_rsp_type  rsp_ff, rsp_in;

   logic          do_push, do_pop1, do_pop2;
   logic [1:0]    mark;
   logic [2:0]    cond_err;
   logic [2:0]    err_cur;
   logic [DW-1:0] depth_m3, depth_m4;

   assign q_pop     = q_valid && (!valid_ff || !rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;
   assign depth_m3  = depth_ff - DW'(3);
   assign depth_m4  = depth_ff - DW'(4);

   always_comb begin
      do_push  = 1'b0;
      do_pop1  = 1'b0;
      do_pop2  = 1'b0;
      mark     = MARK_IF;
      cond_err = ERR_NONE;
      depth_in = depth_ff;
      case (q_item.cond_op) inside
         COND_IF, COND_NOTIF, COND_ELSE: begin
            mark = (q_item.cond_op == COND_IF)    ? MARK_IF :
                   (q_item.cond_op == COND_NOTIF) ? MARK_NOTIF : MARK_ELSE;
            if (depth_ff >= FULL_DEPTH) begin
               cond_err = ERR_OVERFLOW;
            end else begin
               do_push  = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
         end
         COND_ENDIF: begin
            if (depth_ff == '0) begin
               cond_err = ERR_UNBALANCED;
            end else if (top_ff == MARK_ELSE) begin
               if (depth_ff == DW'(1)) begin
                  cond_err = ERR_UNBALANCED;
                  depth_in = '0;
               end else begin
                  do_pop2  = 1'b1;
                  depth_in = depth_ff - DW'(2);
                  // An ELSE below the ELSE has no IF or NOTIF partner.
                  if (second_ff == MARK_ELSE) begin
                     cond_err = ERR_UNBALANCED;
                  end
               end
            end else begin
               do_pop1  = 1'b1;
               depth_in = depth_ff - DW'(1);
            end
         end
         default: ;
      endcase

      // Keep only the first error of the script, in order of checking.
      err_cur = err_ff;
      if (err_cur == ERR_NONE) err_cur = q_item.pre_error;
      if (err_cur == ERR_NONE) err_cur = cond_err;
      if ((err_cur == ERR_NONE) && q_item.truncated) err_cur = ERR_PUSH_SIZE;
      if ((err_cur == ERR_NONE) && q_item.script_done && (depth_in != '0)) begin
         err_cur = ERR_UNBALANCED;
      end

      rsp_in.byte_echo        = q_item.byte_echo;
      rsp_in.byte_role        = q_item.byte_role;
      rsp_in.current_opcode   = q_item.current_opcode;
      rsp_in.instruction_done = q_item.instruction_done;
      rsp_in.push_size        = q_item.push_size;
      rsp_in.error_code       = err_cur;
      rsp_in.script_done      = q_item.script_done;

      err_in = q_item.script_done ? ERR_NONE : err_cur;
      if (q_item.script_done) begin
         depth_in = '0;
      end
   end

   // Stack memory and top-of-stack cache.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         if (do_push) begin
            stack_mem[depth_ff[AW-1:0]] <= mark;
            top_ff    <= mark;
            second_ff <= top_ff;
         end else if (do_pop1) begin
            top_ff    <= second_ff;
            second_ff <= stack_mem[depth_m3[AW-1:0]];
         end else if (do_pop2) begin
            top_ff    <= stack_mem[depth_m3[AW-1:0]];
            second_ff <= stack_mem[depth_m4[AW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         depth_ff <= '0;
         err_ff   <= ERR_NONE;
      end else begin
         if (q_pop) begin
            valid_ff <= 1'b1;
            depth_ff <= depth_in;
            err_ff   <= err_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/script_opcode_stream_validator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// script_opcode_stream_validator_unit
// Tags each script byte as opcode, push length or push data and validates
// the script: opcodes, minimal pushes, push sizes and conditional nesting.
// ----------------------------------------------------------------------------
// Use of the block:
// A script is sent one byte per transfer on the req_ channel, with
// end_of_script set on its final byte. Every byte gives exactly one
// transfer on the rsp_ channel, in order, carrying the byte, its role, the
// opcode it belongs to, the decoded push size and the first error of the
// script so far; on the final byte error_code covers the whole script.
// Each byte is written into the queue and then into the result register
// before rsp_valid rises for it. One byte is taken every cycle while the
// queue has room, as the front parser updates its push state as each byte
// is taken and the back stage updates the conditional stack and error latch
// once per byte, using two registered top entries and a memory read for
// the entries below them.
// A queue of QUEUE_DEPTH entries separates the two halves. When rsp_stall
// is high the result register holds, the queue fills and req_stall rises
// once it is full; no transfer is lost. Reset clears the parse state, the
// stack depth, the queue and the result valid, and restores the
// configuration defaults. The stack memory needs no clearing pass.
// Configuration writes are always accepted (csr_ready is high) and must be
// made only while no script byte is in flight.
// ----------------------------------------------------------------------------
module script_opcode_stream_validator_unit #(
   parameter int COND_DEPTH  = sotv_pkg::COND_DEPTH_DEFAULT,
   parameter int QUEUE_DEPTH = sotv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   // Script byte channel.
   input  wire                                req_valid,
   output logic                               req_stall,
   input  sotv_pkg::sotv_req_type             req_data,
   // Result channel.
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output sotv_pkg::sotv_rsp_type             rsp_data,
   // Configuration write channel.
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [sotv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire [sotv_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sotv_pkg::*;

   sotv_cfg_type  cfg_ff;
   sotv_item_type front_item;
   sotv_item_type q_item;
   logic          req_accept;
   logic          q_full;
   logic          q_valid;
   logic          q_pop;

   // Configuration registers; an index beyond the list is ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.minimal_push_check     <= 1'b0;
         cfg_ff.first_undefined_opcode <= FIRST_UNDEFINED_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MINIMAL_PUSH_CHECK:     cfg_ff.minimal_push_check <= csr_data[0];
            CSR_FIRST_UNDEFINED_OPCODE: cfg_ff.first_undefined_opcode <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // A byte is taken whenever the queue has room.
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   sotv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_item (req_data),
      .cfg      (cfg_ff),
      .item     (front_item)
   );

   sotv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_accept),
      .wr_item  (front_item),
      .full     (q_full),
      .rd_pop   (q_pop),
      .rd_valid (q_valid),
      .rd_item  (q_item)
   );

   sotv_back #(
      .COND_DEPTH (COND_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: hw/rtl/sotv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sotv_checker
// Port-level checks of the validator's result stream, bound to the top.
// ----------------------------------------------------------------------------
module sotv_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input sotv_pkg::sotv_rsp_type rsp_data
);
   import sotv_pkg::*;

   // A result waiting on a stalled receiver stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // An opcode byte is its own instruction's opcode.
   a_opcode_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.byte_role == ROLE_OPCODE) |->
         (rsp_data.current_opcode == rsp_data.byte_echo))
      else $error("opcode byte not held as current opcode");

   // A push length byte only completes a zero-length push.
   a_zero_length_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.byte_role == ROLE_LENGTH) && rsp_data.instruction_done |->
         (rsp_data.push_size == 32'd0))
      else $error("length byte completed a non-empty push");

endmodule

bind script_opcode_stream_validator_unit sotv_checker u_sotv_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
